FILE: rtl/pcef_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Charger event sequencer package
// Item types, port states, event, action and host update codes shared by
// the sequencer core and its step logic.
// ----------------------------------------------------------------------------
package pcef_pkg;

    localparam int unsigned EV_W    = 5;
    localparam int unsigned ST_W    = 3;
    localparam int unsigned REP_W   = 4;
    localparam int unsigned ACT_W   = 3;
    localparam int unsigned HU_W    = 3;
    localparam int unsigned BATT_W  = 7;

    // Port states
    typedef enum logic [ST_W-1:0] {
        ST_RESET       = 3'd0,
        ST_INIT        = 3'd1,
        ST_ENABLED     = 3'd2,
        ST_DETECTED    = 3'd3,
        ST_CONNECTED   = 3'd4,
        ST_CHARGING    = 3'd5,
        ST_DOWNLOAD    = 3'd6,
        ST_DOWNLOADING = 3'd7
    } t_port_state;

    // Reported state code for a connected port at or above the full level
    localparam logic [REP_W-1:0] REP_FULL = 4'd8;

    // Event codes
    localparam logic [EV_W-1:0] EV_NONE        = 5'd0;
    localparam logic [EV_W-1:0] EV_RESET       = 5'd1;
    localparam logic [EV_W-1:0] EV_ENABLED     = 5'd3;
    localparam logic [EV_W-1:0] EV_DISABLED    = 5'd4;
    localparam logic [EV_W-1:0] EV_DETECTED    = 5'd5;
    localparam logic [EV_W-1:0] EV_CONNECTED   = 5'd6;
    localparam logic [EV_W-1:0] EV_LOST        = 5'd7;
    localparam logic [EV_W-1:0] EV_CHG_STARTED = 5'd8;
    localparam logic [EV_W-1:0] EV_CHG_UPDATE  = 5'd9;
    localparam logic [EV_W-1:0] EV_CHG_ENDED   = 5'd10;
    localparam logic [EV_W-1:0] EV_CHG_STOPPED = 5'd11;
    localparam logic [EV_W-1:0] EV_UPD_OPENED  = 5'd12;
    localparam logic [EV_W-1:0] EV_UPD_CLOSED  = 5'd13;
    localparam logic [EV_W-1:0] EV_UPD_WRITTEN = 5'd14;
    localparam logic [EV_W-1:0] EV_IN_NORMAL   = 5'd15;
    localparam logic [EV_W-1:0] EV_CHG_ERROR   = 5'd16;
    localparam logic [EV_W-1:0] EV_UPD_ERROR   = 5'd17;
    localparam logic [EV_W-1:0] EV_ENABLE      = 5'd19;
    localparam logic [EV_W-1:0] EV_DISABLE     = 5'd20;
    localparam logic [EV_W-1:0] EV_UPD_OPEN    = 5'd21;
    localparam logic [EV_W-1:0] EV_UPD_WRITE   = 5'd22;
    localparam logic [EV_W-1:0] EV_UPD_CLOSE   = 5'd23;
    localparam logic [EV_W-1:0] EV_LAST        = 5'd23;

    // Driver status and host power codes
    localparam logic [1:0] DS_OK    = 2'd0;
    localparam logic [1:0] PWR_OFF  = 2'd0;
    localparam logic [1:0] PWR_SUSP = 2'd1;

    // Driver actions
    localparam logic [ACT_W-1:0] ACT_NONE    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_INIT    = 3'd1;
    localparam logic [ACT_W-1:0] ACT_ENABLE  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_DISABLE = 3'd3;
    localparam logic [ACT_W-1:0] ACT_GETCHG  = 3'd4;
    localparam logic [ACT_W-1:0] ACT_OPEN    = 3'd5;
    localparam logic [ACT_W-1:0] ACT_WRITE   = 3'd6;
    localparam logic [ACT_W-1:0] ACT_CLOSE   = 3'd7;

    // Host update events
    localparam logic [HU_W-1:0] HU_NONE    = 3'd0;
    localparam logic [HU_W-1:0] HU_ERROR   = 3'd1;
    localparam logic [HU_W-1:0] HU_OPENED  = 3'd2;
    localparam logic [HU_W-1:0] HU_WRITTEN = 3'd3;
    localparam logic [HU_W-1:0] HU_CLOSED  = 3'd4;

    localparam logic [BATT_W-1:0] BATT_MAX        = 7'd100;
    localparam logic [BATT_W-1:0] FULL_LEVEL_RST  = 7'd100;

    typedef struct packed {
        logic [EV_W-1:0]   event_req;
        logic [1:0]        driver_status;
        logic              download_mode;
        logic [1:0]        power_state;
        logic              update_data_ready;
        logic              battery_valid;
        logic [BATT_W-1:0] battery_report;
    } t_in_item;

    typedef struct packed {
        logic [REP_W-1:0]  reported_state;
        logic              notify_host;
        logic [HU_W-1:0]   host_update_event;
        logic [EV_W-1:0]   followup_event;
        logic [ACT_W-1:0]  driver_action;
        logic [BATT_W-1:0] battery_level;
        logic              host_disabled;
    } t_out_item;

    // Port context carried from item to item
    typedef struct packed {
        t_port_state       state;
        logic              disable_flag;
        logic [BATT_W-1:0] battery;
    } t_port_ctx;

endpackage

FILE: rtl/peripheral_charger_event_fsm_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Peripheral charger event sequencer core
// Steps an eight-state charger port machine, one translated event per item.
// ----------------------------------------------------------------------------
// Each input item carries one charger event with the driver status, port mode,
// host power state and an optional battery report; each one yields exactly one
// result item with the reported port state (full when connected at or above
// the configured full level), the driver action to start, any follow-up event
// and firmware-update host event, the notify flag, the held battery level and
// the host-disable flag. Throughput is one item per cycle when unstalled: an
// item is captured in the input register, decoded against the port context in
// one pass of combinational logic and written to the result register, which
// also commits the new context. While a result waits on i_out_stall the decoded
// item holds in the input register; an empty input register still takes one
// more item, and o_in_stall rises only once both registers are full and the
// result is stalled. The full level resets to 100; the user writes it through
// i_cfg_we / i_cfg_wdata only while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module peripheral_charger_event_fsm_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,

    input  logic                             i_cfg_we,
    input  logic [pcef_pkg::BATT_W-1:0]      i_cfg_wdata,

    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  pcef_pkg::t_in_item               i_in,

    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output pcef_pkg::t_out_item              o_out
);

    // Configuration
    logic [pcef_pkg::BATT_W-1:0] r_full_level;

    // Input register
    logic                        r_in_valid;
    pcef_pkg::t_in_item          r_in;

    // Port context, committed as each item leaves the decode stage
    pcef_pkg::t_port_ctx         r_ctx;
    pcef_pkg::t_port_ctx         n_ctx;

    // Result register
    logic                        r_out_valid;
    pcef_pkg::t_out_item         r_out;
    pcef_pkg::t_out_item         n_out;

    logic                        adv;
    logic                        in_take;

    // Advance the decoded item when the result register is free or draining
    assign adv        = r_in_valid && (!r_out_valid || !i_out_stall);
    assign in_take    = i_in_valid && (!r_in_valid || adv);
    assign o_in_stall = r_in_valid && !adv;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    pcef_step u_step (
        .i_item       (r_in),
        .i_ctx        (r_ctx),
        .i_full_level (r_full_level),
        .o_ctx        (n_ctx),
        .o_res        (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_level <= pcef_pkg::FULL_LEVEL_RST;
        end else if (i_cfg_we) begin
            r_full_level <= i_cfg_wdata;
        end
    end

    // Input stage: take a new item when empty or when the current one moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in;
        end
    end

    // Context: update only when the item is committed to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx.state        <= pcef_pkg::ST_RESET;
            r_ctx.disable_flag <= 1'b0;
            r_ctx.battery      <= '0;
        end else if (adv) begin
            r_ctx <= n_ctx;
        end
    end

    // Result stage: hold while stalled, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_out;
        end
    end

endmodule

FILE: rtl/pcef_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Charger event step logic
// Decodes one event against the port context: next context and result item.
// ----------------------------------------------------------------------------
module pcef_step (
    input  pcef_pkg::t_in_item               i_item,
    input  pcef_pkg::t_port_ctx              i_ctx,
    input  logic [pcef_pkg::BATT_W-1:0]      i_full_level,
    output pcef_pkg::t_port_ctx              o_ctx,
    output pcef_pkg::t_out_item              o_res
);

    logic [pcef_pkg::EV_W-1:0]   ev;
    logic                        ds_ok;
    logic                        ds_fail;
    logic                        dis_eff;
    logic [pcef_pkg::BATT_W-1:0] batt_in;
    pcef_pkg::t_port_state       st;
    pcef_pkg::t_port_state       st_n;
    logic                        dis_n;
    logic [pcef_pkg::BATT_W-1:0] batt_n;
    logic [pcef_pkg::ACT_W-1:0]  act;
    logic [pcef_pkg::HU_W-1:0]   hup;
    logic [pcef_pkg::EV_W-1:0]   follow;
    logic                        notify;

    // Unknown codes behave as no event; status 2 and 3 both count as failure
    assign ev      = (i_item.event_req > pcef_pkg::EV_LAST) ? pcef_pkg::EV_NONE
                                                            : i_item.event_req;
    assign ds_ok   = (i_item.driver_status == pcef_pkg::DS_OK);
    assign ds_fail = i_item.driver_status[1];
    assign st      = i_ctx.state;
    assign dis_eff = (ev == pcef_pkg::EV_ENABLE) ? 1'b0 : i_ctx.disable_flag;

    // Battery report lands before the event, saturated at full scale
    always_comb begin
        batt_in = i_ctx.battery;
        if (i_item.battery_valid) begin
            batt_in = (i_item.battery_report > pcef_pkg::BATT_MAX) ? pcef_pkg::BATT_MAX
                                                                   : i_item.battery_report;
        end
    end

    always_comb begin
        st_n   = st;
        dis_n  = i_ctx.disable_flag;
        batt_n = batt_in;
        act    = pcef_pkg::ACT_NONE;
        hup    = pcef_pkg::HU_NONE;
        follow = pcef_pkg::EV_NONE;

        if (ev == pcef_pkg::EV_NONE) begin
            // hold
        end else if (ev == pcef_pkg::EV_RESET) begin
            if (!(st == pcef_pkg::ST_INIT && i_ctx.disable_flag)) begin
                batt_n = '0;
                dis_n  = 1'b0;
                if (!i_item.download_mode) begin
                    act = pcef_pkg::ACT_INIT;
                    if (ds_ok) begin
                        st_n   = pcef_pkg::ST_INIT;
                        follow = pcef_pkg::EV_ENABLE;
                    end else begin
                        st_n = pcef_pkg::ST_RESET;
                    end
                end else begin
                    st_n   = pcef_pkg::ST_DOWNLOAD;
                    follow = pcef_pkg::EV_UPD_OPEN;
                end
            end
        end else begin
            unique case (st)
                pcef_pkg::ST_RESET: begin
                    if (ev == pcef_pkg::EV_IN_NORMAL) begin
                        st_n   = pcef_pkg::ST_INIT;
                        follow = pcef_pkg::EV_ENABLE;
                    end
                end
                pcef_pkg::ST_INIT: begin
                    dis_n = dis_eff;
                    if (!dis_eff) begin
                        priority if (ev == pcef_pkg::EV_ENABLE) begin
                            act = pcef_pkg::ACT_ENABLE;
                            if (ds_ok) st_n = pcef_pkg::ST_ENABLED;
                        end else if (ev == pcef_pkg::EV_ENABLED) begin
                            st_n = pcef_pkg::ST_ENABLED;
                        end else begin
                            st_n = st;
                        end
                    end
                end
                pcef_pkg::ST_ENABLED, pcef_pkg::ST_DETECTED,
                pcef_pkg::ST_CONNECTED, pcef_pkg::ST_CHARGING: begin
                    priority if (ev == pcef_pkg::EV_DISABLE) begin
                        dis_n = 1'b1;
                        act   = pcef_pkg::ACT_DISABLE;
                        if (ds_ok) st_n = pcef_pkg::ST_INIT;
                    end else if (ev == pcef_pkg::EV_DISABLED) begin
                        st_n = pcef_pkg::ST_INIT;
                    end else if (ev == pcef_pkg::EV_DETECTED && st == pcef_pkg::ST_ENABLED) begin
                        st_n = pcef_pkg::ST_DETECTED;
                    end else if (ev == pcef_pkg::EV_CONNECTED &&
                                 (st == pcef_pkg::ST_ENABLED ||
                                  st == pcef_pkg::ST_DETECTED)) begin
                        act  = pcef_pkg::ACT_GETCHG;
                        st_n = pcef_pkg::ST_CONNECTED;
                    end else if (ev == pcef_pkg::EV_LOST && st != pcef_pkg::ST_ENABLED) begin
                        batt_n = '0;
                        st_n   = pcef_pkg::ST_ENABLED;
                    end else if (ev == pcef_pkg::EV_CHG_STARTED &&
                                 st == pcef_pkg::ST_CONNECTED) begin
                        st_n = pcef_pkg::ST_CHARGING;
                    end else if (ev == pcef_pkg::EV_CHG_ERROR &&
                                 (st == pcef_pkg::ST_CONNECTED ||
                                  st == pcef_pkg::ST_CHARGING)) begin
                        st_n = pcef_pkg::ST_INIT;
                    end else if ((ev == pcef_pkg::EV_CHG_ENDED ||
                                  ev == pcef_pkg::EV_CHG_STOPPED) &&
                                 st == pcef_pkg::ST_CHARGING) begin
                        st_n = pcef_pkg::ST_CONNECTED;
                    end else begin
                        st_n = st;
                    end
                end
                pcef_pkg::ST_DOWNLOAD: begin
                    priority if (ev == pcef_pkg::EV_UPD_OPEN) begin
                        act = pcef_pkg::ACT_OPEN;
                        if (ds_ok)        st_n = pcef_pkg::ST_DOWNLOADING;
                        else if (ds_fail) hup  = pcef_pkg::HU_ERROR;
                    end else if (ev == pcef_pkg::EV_UPD_OPENED) begin
                        st_n = pcef_pkg::ST_DOWNLOADING;
                        hup  = pcef_pkg::HU_OPENED;
                    end else if (ev == pcef_pkg::EV_UPD_ERROR) begin
                        hup = pcef_pkg::HU_ERROR;
                    end else begin
                        st_n = st;
                    end
                end
                pcef_pkg::ST_DOWNLOADING: begin
                    priority if (ev == pcef_pkg::EV_UPD_WRITE) begin
                        // Write without data does nothing
                        if (i_item.update_data_ready) begin
                            act = pcef_pkg::ACT_WRITE;
                            if (ds_fail) hup = pcef_pkg::HU_ERROR;
                        end
                    end else if (ev == pcef_pkg::EV_UPD_WRITTEN) begin
                        hup = pcef_pkg::HU_WRITTEN;
                    end else if (ev == pcef_pkg::EV_UPD_CLOSE) begin
                        act = pcef_pkg::ACT_CLOSE;
                        if (ds_ok)        st_n = pcef_pkg::ST_DOWNLOAD;
                        else if (ds_fail) hup  = pcef_pkg::HU_ERROR;
                    end else if (ev == pcef_pkg::EV_UPD_CLOSED) begin
                        st_n = pcef_pkg::ST_DOWNLOAD;
                        hup  = pcef_pkg::HU_CLOSED;
                    end else if (ev == pcef_pkg::EV_UPD_ERROR) begin
                        hup = pcef_pkg::HU_ERROR;
                    end else begin
                        st_n = st;
                    end
                end
                default: st_n = st;
            endcase
        end
    end

    // Host notification depends on power state and the battery after the step
    always_comb begin
        priority if (ev == pcef_pkg::EV_NONE || i_item.power_state == pcef_pkg::PWR_OFF) begin
            notify = 1'b0;
        end else if (i_item.power_state == pcef_pkg::PWR_SUSP) begin
            notify = (ev == pcef_pkg::EV_DETECTED) || (ev == pcef_pkg::EV_LOST);
        end else if (ev == pcef_pkg::EV_CHG_UPDATE) begin
            notify = (batt_n != i_ctx.battery);
        end else if (ev == pcef_pkg::EV_UPD_OPENED || ev == pcef_pkg::EV_UPD_CLOSED ||
                     ev == pcef_pkg::EV_UPD_WRITTEN || ev == pcef_pkg::EV_UPD_ERROR ||
                     ev == pcef_pkg::EV_UPD_OPEN || ev == pcef_pkg::EV_UPD_WRITE ||
                     ev == pcef_pkg::EV_UPD_CLOSE) begin
            notify = 1'b0;
        end else begin
            notify = 1'b1;
        end
    end

    always_comb begin
        o_ctx.state        = st_n;
        o_ctx.disable_flag = dis_n;
        o_ctx.battery      = batt_n;

        o_res.reported_state    = {1'b0, st_n};
        if (st_n == pcef_pkg::ST_CONNECTED && batt_n >= i_full_level) begin
            o_res.reported_state = pcef_pkg::REP_FULL;
        end
        o_res.notify_host       = notify;
        o_res.host_update_event = hup;
        o_res.followup_event    = follow;
        o_res.driver_action     = act;
        o_res.battery_level     = batt_n;
        o_res.host_disabled     = dis_n;
    end

endmodule

FILE: sim/peripheral_charger_event_fsm_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Charger event sequencer core testbench
// Drives charger event items into the core with random idle cycles on the
// sender and random stalls on the receiver. A port model in the bench tracks
// the port state, host-disable flag, battery level and full level, and works
// out the result of every accepted item. Each accepted result is checked
// field by field against the oldest outstanding expectation. A short table of
// hand-picked events runs first; weighted random event sequences follow, over
// several full-level settings.
// ----------------------------------------------------------------------------
module peripheral_charger_event_fsm_core_test;

    import pcef_pkg::*;

    // Codes the core never decodes but which still reach the notify logic
    localparam logic [EV_W-1:0] EV_INITIALIZED = 5'd2;
    localparam logic [EV_W-1:0] EV_OTHER_ERROR = 5'd18;

    // Driver status and power codes missing from the package
    localparam logic [1:0] DS_BUSY = 2'd1;
    localparam logic [1:0] DS_FAIL = 2'd2;
    localparam logic [1:0] DS_BAD  = 2'd3;
    localparam logic [1:0] PWR_ON  = 2'd2;
    localparam logic [1:0] PWR_BAD = 2'd3;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned PHASE_ITEMS  = 200;
    localparam int unsigned NUM_PHASES   = 5;
    localparam int unsigned IDLE_PCT     = 27;
    localparam int unsigned DRAIN_CYCLES = 8;

    // One row of the directed table: the item, and optionally a result typed in
    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item res;
    } dir_row_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [BATT_W-1:0] i_cfg_wdata;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_item    i_in;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_item   o_out;

    // Port model state, mirrored from the core's context
    t_port_state       port_q;
    logic              disable_q;
    logic [BATT_W-1:0] batt_q;
    logic [BATT_W-1:0] full_lvl_q;

    t_out_item   expected_q[$];
    dir_row_t    dir_tab[$];
    int unsigned errors;
    int unsigned cycles;
    int unsigned idle_pct;
    int unsigned stall_pct;

    peripheral_charger_event_fsm_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver: stall at random, changing only on the falling edge
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Check every accepted result against the oldest expectation
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_q.size() == 0) begin
                $error("unexpected result item: %p", o_out);
                errors++;
            end else begin
                want = expected_q.pop_front();
                if (o_out.reported_state !== want.reported_state) begin
                    $error("reported_state: expected %0d actual %0d",
                           want.reported_state, o_out.reported_state);
                    errors++;
                end
                if (o_out.notify_host !== want.notify_host) begin
                    $error("notify_host: expected %0d actual %0d",
                           want.notify_host, o_out.notify_host);
                    errors++;
                end
                if (o_out.host_update_event !== want.host_update_event) begin
                    $error("host_update_event: expected %0d actual %0d",
                           want.host_update_event, o_out.host_update_event);
                    errors++;
                end
                if (o_out.followup_event !== want.followup_event) begin
                    $error("followup_event: expected %0d actual %0d",
                           want.followup_event, o_out.followup_event);
                    errors++;
                end
                if (o_out.driver_action !== want.driver_action) begin
                    $error("driver_action: expected %0d actual %0d",
                           want.driver_action, o_out.driver_action);
                    errors++;
                end
                if (o_out.battery_level !== want.battery_level) begin
                    $error("battery_level: expected %0d actual %0d",
                           want.battery_level, o_out.battery_level);
                    errors++;
                end
                if (o_out.host_disabled !== want.host_disabled) begin
                    $error("host_disabled: expected %0d actual %0d",
                           want.host_disabled, o_out.host_disabled);
                    errors++;
                end
            end
        end
    end

    // Build an input item from its fields
    function automatic t_in_item mk_in(input logic [EV_W-1:0] ev, input logic [1:0] ds,
                                       input logic mode, input logic [1:0] pwr,
                                       input logic rdy, input logic bv,
                                       input logic [BATT_W-1:0] br);
        t_in_item it;
        it.event_req         = ev;
        it.driver_status     = ds;
        it.download_mode     = mode;
        it.power_state       = pwr;
        it.update_data_ready = rdy;
        it.battery_valid     = bv;
        it.battery_report    = br;
        return it;
    endfunction

    // Advance the port model by one event item and return its result
    function automatic t_out_item advance_port(input t_in_item it);
        t_out_item         res;
        t_port_state       cur;
        logic [EV_W-1:0]   ev;
        logic [1:0]        ds;
        logic              ds_fail;
        logic [BATT_W-1:0] prev_batt;
        res       = '0;
        cur       = port_q;
        // Codes past the last event count as no event
        ev        = (it.event_req > EV_LAST) ? EV_NONE : it.event_req;
        ds        = it.driver_status;
        // Any status other than success or in progress is a failure
        ds_fail   = (ds != DS_OK) && (ds != DS_BUSY);
        prev_batt = batt_q;

        // Take a battery report before the event, saturating at the maximum
        if (it.battery_valid)
            batt_q = (it.battery_report > BATT_MAX) ? BATT_MAX : it.battery_report;

        if (ev == EV_RESET) begin
            // Hold in the initialised state while the host has it disabled
            if (!(cur == ST_INIT && disable_q)) begin
                batt_q    = '0;
                disable_q = 1'b0;
                if (!it.download_mode) begin
                    res.driver_action = ACT_INIT;
                    if (ds == DS_OK) begin
                        port_q             = ST_INIT;
                        res.followup_event = EV_ENABLE;
                    end else begin
                        port_q = ST_RESET;
                    end
                end else begin
                    port_q             = ST_DOWNLOAD;
                    res.followup_event = EV_UPD_OPEN;
                end
            end
        end else if (ev != EV_NONE) begin
            case (cur)
                ST_RESET: begin
                    if (ev == EV_IN_NORMAL) begin
                        port_q             = ST_INIT;
                        res.followup_event = EV_ENABLE;
                    end
                end
                ST_INIT: begin
                    // Enable clears the disable flag before anything else
                    if (ev == EV_ENABLE)
                        disable_q = 1'b0;
                    if (!disable_q) begin
                        if (ev == EV_ENABLE) begin
                            res.driver_action = ACT_ENABLE;
                            if (ds == DS_OK)
                                port_q = ST_ENABLED;
                        end else if (ev == EV_ENABLED) begin
                            port_q = ST_ENABLED;
                        end
                    end
                end
                ST_ENABLED, ST_DETECTED, ST_CONNECTED, ST_CHARGING: begin
                    if (ev == EV_DISABLE) begin
                        disable_q         = 1'b1;
                        res.driver_action = ACT_DISABLE;
                        if (ds == DS_OK)
                            port_q = ST_INIT;
                    end else if (ev == EV_DISABLED) begin
                        port_q = ST_INIT;
                    end else if (ev == EV_DETECTED && cur == ST_ENABLED) begin
                        port_q = ST_DETECTED;
                    end else if (ev == EV_CONNECTED &&
                                 (cur == ST_ENABLED || cur == ST_DETECTED)) begin
                        // Get-charge status is ignored
                        res.driver_action = ACT_GETCHG;
                        port_q            = ST_CONNECTED;
                    end else if (ev == EV_LOST && cur != ST_ENABLED) begin
                        batt_q = '0;
                        port_q = ST_ENABLED;
                    end else if (ev == EV_CHG_STARTED && cur == ST_CONNECTED) begin
                        port_q = ST_CHARGING;
                    end else if (ev == EV_CHG_ERROR &&
                                 (cur == ST_CONNECTED || cur == ST_CHARGING)) begin
                        port_q = ST_INIT;
                    end else if ((ev == EV_CHG_ENDED || ev == EV_CHG_STOPPED) &&
                                 cur == ST_CHARGING) begin
                        port_q = ST_CONNECTED;
                    end
                end
                ST_DOWNLOAD: begin
                    if (ev == EV_UPD_OPEN) begin
                        res.driver_action = ACT_OPEN;
                        if (ds == DS_OK)
                            port_q = ST_DOWNLOADING;
                        else if (ds_fail)
                            res.host_update_event = HU_ERROR;
                    end else if (ev == EV_UPD_OPENED) begin
                        port_q                = ST_DOWNLOADING;
                        res.host_update_event = HU_OPENED;
                    end else if (ev == EV_UPD_ERROR) begin
                        res.host_update_event = HU_ERROR;
                    end
                end
                default: begin
                    // Downloading: a write with no data waiting does nothing
                    if (ev == EV_UPD_WRITE) begin
                        if (it.update_data_ready) begin
                            res.driver_action = ACT_WRITE;
                            if (ds_fail)
                                res.host_update_event = HU_ERROR;
                        end
                    end else if (ev == EV_UPD_WRITTEN) begin
                        res.host_update_event = HU_WRITTEN;
                    end else if (ev == EV_UPD_CLOSE) begin
                        res.driver_action = ACT_CLOSE;
                        if (ds == DS_OK)
                            port_q = ST_DOWNLOAD;
                        else if (ds_fail)
                            res.host_update_event = HU_ERROR;
                    end else if (ev == EV_UPD_CLOSED) begin
                        port_q                = ST_DOWNLOAD;
                        res.host_update_event = HU_CLOSED;
                    end else if (ev == EV_UPD_ERROR) begin
                        res.host_update_event = HU_ERROR;
                    end
                end
            endcase
        end

        // Connected at or above the full level reads as full
        if (port_q == ST_CONNECTED && batt_q >= full_lvl_q)
            res.reported_state = REP_FULL;
        else
            res.reported_state = REP_W'(port_q);

        // Power code 3 falls through to the "on" rules
        if (ev == EV_NONE || it.power_state == PWR_OFF)
            res.notify_host = 1'b0;
        else if (it.power_state == PWR_SUSP)
            res.notify_host = (ev == EV_DETECTED || ev == EV_LOST);
        else if (ev == EV_CHG_UPDATE)
            res.notify_host = (batt_q != prev_batt);
        else
            res.notify_host = !(ev == EV_UPD_OPENED || ev == EV_UPD_CLOSED ||
                                ev == EV_UPD_WRITTEN || ev == EV_UPD_ERROR ||
                                ev == EV_UPD_OPEN || ev == EV_UPD_WRITE ||
                                ev == EV_UPD_CLOSE);

        res.battery_level = batt_q;
        res.host_disabled = disable_q;
        return res;
    endfunction

    // Pick an event that moves the port along from where the model stands,
    // with some noise and the odd reset mixed in
    function automatic t_in_item random_event();
        t_in_item        it;
        logic [EV_W-1:0] menu[$];
        int unsigned     pick;
        int unsigned     k;
        case (port_q)
            ST_RESET:       menu = '{EV_RESET, EV_IN_NORMAL, EV_INITIALIZED};
            ST_INIT:        menu = '{EV_ENABLE, EV_ENABLE, EV_ENABLED, EV_RESET,
                                     EV_DISABLE, EV_NONE};
            ST_ENABLED:     menu = '{EV_DETECTED, EV_CONNECTED, EV_DISABLE,
                                     EV_DISABLED, EV_LOST};
            ST_DETECTED:    menu = '{EV_CONNECTED, EV_CONNECTED, EV_LOST, EV_DISABLE,
                                     EV_OTHER_ERROR};
            ST_CONNECTED:   menu = '{EV_CHG_STARTED, EV_CHG_UPDATE, EV_CHG_UPDATE,
                                     EV_LOST, EV_CHG_ERROR, EV_DISABLE, EV_NONE};
            ST_CHARGING:    menu = '{EV_CHG_UPDATE, EV_CHG_UPDATE, EV_CHG_ENDED,
                                     EV_CHG_STOPPED, EV_CHG_ERROR, EV_LOST,
                                     EV_DISABLED};
            ST_DOWNLOAD:    menu = '{EV_UPD_OPEN, EV_UPD_OPEN, EV_UPD_OPENED,
                                     EV_UPD_ERROR, EV_RESET};
            default:        menu = '{EV_UPD_WRITE, EV_UPD_WRITE, EV_UPD_WRITTEN,
                                     EV_UPD_CLOSE, EV_UPD_CLOSED, EV_UPD_ERROR,
                                     EV_RESET};
        endcase

        pick = $urandom_range(0, 99);
        if (pick < 20)
            it.event_req = EV_W'($urandom);
        else if (pick < 26)
            it.event_req = EV_RESET;
        else
            it.event_req = menu[$urandom_range(0, menu.size() - 1)];

        // Mostly successful driver actions so that sequences get deep
        it.driver_status     = ($urandom_range(0, 3) != 0) ? DS_OK
                                                           : 2'($urandom_range(0, 3));
        it.download_mode     = ($urandom_range(0, 3) == 0);
        it.power_state       = 2'($urandom_range(0, 3));
        it.update_data_ready = ($urandom_range(0, 3) != 0);
        it.battery_valid     = ($urandom_range(0, 9) < 4);

        // Bias reports to the full-level boundary; sometimes past the maximum
        k = $urandom_range(0, 9);
        if (k == 0)
            it.battery_report = BATT_W'($urandom_range(101, 127));
        else if (k == 1)
            it.battery_report = full_lvl_q;
        else if (k == 2)
            it.battery_report = BATT_MAX;
        else
            it.battery_report = BATT_W'($urandom_range(0, 100));
        return it;
    endfunction

    // Offer one item, idling at random first; record its expected result
    // at the edge where it is taken
    task automatic send_event(input t_in_item it, input bit typed, input t_out_item res);
        t_out_item pred;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= it;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        pred = advance_port(it);
        expected_q.push_back(typed ? res : pred);
    endtask

    // Drop valid and hold until every outstanding result has come back
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(negedge i_clk);
    endtask

    // Write the full level while the core is idle
    task automatic set_full_level(input logic [BATT_W-1:0] lvl);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= lvl;
        @(posedge i_clk);
        full_lvl_q = lvl;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        logic [BATT_W-1:0] levels[NUM_PHASES];
        t_out_item         none_res;
        int unsigned       ph;
        int unsigned       n;

        // Drive everything known from time zero
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        i_in_valid  = 1'b0;
        i_in        = '0;
        i_out_stall = 1'b0;
        errors      = 0;
        cycles      = 0;
        idle_pct    = IDLE_PCT;
        stall_pct   = IDLE_PCT;
        port_q      = ST_RESET;
        disable_q   = 1'b0;
        batt_q      = '0;
        full_lvl_q  = FULL_LEVEL_RST;
        none_res    = '0;

        // Directed events from reset, full level at its reset value
        dir_tab.push_back('{mk_in(EV_NONE, DS_OK, 1'b0, PWR_OFF, 1'b0, 1'b0, 7'd0),
                           1'b1, '{4'(ST_RESET), 1'b0, HU_NONE, EV_NONE, ACT_NONE,
                                  7'd0, 1'b0}});
        // Unknown code acts as no event; an over-range report saturates
        dir_tab.push_back('{mk_in(5'd31, DS_BAD, 1'b1, PWR_BAD, 1'b1, 1'b1, 7'd127),
                           1'b1, '{4'(ST_RESET), 1'b0, HU_NONE, EV_NONE, ACT_NONE,
                                  BATT_MAX, 1'b0}});
        dir_tab.push_back('{mk_in(EV_IN_NORMAL, DS_OK, 1'b0, PWR_ON, 1'b0, 1'b0, 7'd0),
                           1'b1, '{4'(ST_INIT), 1'b1, HU_NONE, EV_ENABLE, ACT_NONE,
                                  BATT_MAX, 1'b0}});
        dir_tab.push_back('{mk_in(EV_DISABLE, DS_OK, 1'b0, PWR_ON, 1'b0, 1'b0, 7'd0),
                           1'b0, none_res});
        dir_tab.push_back('{mk_in(EV_RESET, DS_FAIL, 1'b0, PWR_ON, 1'b0, 1'b0, 7'd0),
                           1'b1, '{4'(ST_RESET), 1'b1, HU_NONE, EV_NONE, ACT_INIT,
                                  7'd0, 1'b0}});
        dir_tab.push_back('{mk_in(EV_RESET, DS_BAD, 1'b0, PWR_ON, 1'b0, 1'b0, 7'd0),
                           1'b0, none_res});
        dir_tab.push_back('{mk_in(EV_RESET, DS_OK, 1'b0, PWR_ON, 1'b0, 1'b0, 7'd0),
                           1'b1, '{4'(ST_INIT), 1'b1, HU_NONE, EV_ENABLE, ACT_INIT,
                                  7'd0, 1'b0}});
        dir_tab.push_back('{mk_in(EV_ENABLE, DS_BUSY, 1'b0, PWR_ON, 1'b0, 1'b0, 7'd0),
                           1'b0, none_res});
        dir_tab.push_back('{mk_in(EV_ENABLE, DS_OK, 1'b0, PWR_ON, 1'b0, 1'b0, 7'd0),
                           1'b0, none_res});
        dir_tab.push_back('{mk_in(EV_DISABLE, DS_BUSY, 1'b0, PWR_ON, 1'b0, 1'b0, 7'd0),
                           1'b0, none_res});
        dir_tab.push_back('{mk_in(EV_DISABLE, DS_OK, 1'b0, PWR_ON, 1'b0, 1'b0, 7'd0),
                           1'b0, none_res});
        // Disabled spin: reset and enabled are both ignored
        dir_tab.push_back('{mk_in(EV_RESET, DS_OK, 1'b1, PWR_ON, 1'b0, 1'b0, 7'd0),
                           1'b0, none_res});
        dir_tab.push_back('{mk_in(EV_ENABLED, DS_OK, 1'b0, PWR_ON, 1'b0, 1'b0, 7'd0),
                           1'b0, none_res});
        dir_tab.push_back('{mk_in(EV_ENABLE, DS_OK, 1'b0, PWR_ON, 1'b0, 1'b0, 7'd0),
                           1'b0, none_res});
        dir_tab.push_back('{mk_in(EV_DETECTED, DS_OK, 1'b0, PWR_SUSP, 1'b0, 1'b0, 7'd0),
                           1'b0, none_res});
        // Get-charge status is ignored, even on failure
        dir_tab.push_back('{mk_in(EV_CONNECTED, DS_FAIL, 1'b0, PWR_OFF, 1'b0, 1'b0, 7'd0),
                           1'b0, none_res});
        dir_tab.push_back('{mk_in(EV_CHG_UPDATE, DS_OK, 1'b0, PWR_ON, 1'b0, 1'b1, 7'd100),
                           1'b1, '{REP_FULL, 1'b1, HU_NONE, EV_NONE, ACT_NONE,
                                  BATT_MAX, 1'b0}});
        dir_tab.push_back('{mk_in(EV_CHG_UPDATE, DS_OK, 1'b0, PWR_ON, 1'b0, 1'b1, 7'd100),
                           1'b0, none_res});
        dir_tab.push_back('{mk_in(EV_CHG_STARTED, DS_OK, 1'b0, PWR_ON, 1'b0, 1'b0, 7'd0),
                           1'b0, none_res});
        dir_tab.push_back('{mk_in(EV_CHG_STOPPED, DS_OK, 1'b0, PWR_ON, 1'b0, 1'b0, 7'd0),
                           1'b0, none_res});
        dir_tab.push_back('{mk_in(EV_LOST, DS_OK, 1'b0, PWR_SUSP, 1'b0, 1'b0, 7'd0),
                           1'b0, none_res});
        dir_tab.push_back('{mk_in(EV_RESET, DS_OK, 1'b1, PWR_ON, 1'b0, 1'b0, 7'd0),
                           1'b1, '{4'(ST_DOWNLOAD), 1'b1, HU_NONE, EV_UPD_OPEN,
                                  ACT_NONE, 7'd0, 1'b0}});
        dir_tab.push_back('{mk_in(EV_UPD_OPEN, DS_FAIL, 1'b0, PWR_ON, 1'b0, 1'b0, 7'd0),
                           1'b1, '{4'(ST_DOWNLOAD), 1'b0, HU_ERROR, EV_NONE, ACT_OPEN,
                                  7'd0, 1'b0}});
        dir_tab.push_back('{mk_in(EV_UPD_OPEN, DS_OK, 1'b0, PWR_ON, 1'b0, 1'b0, 7'd0),
                           1'b0, none_res});
        // Write without data waiting does nothing
        dir_tab.push_back('{mk_in(EV_UPD_WRITE, DS_OK, 1'b0, PWR_ON, 1'b0, 1'b0, 7'd0),
                           1'b0, none_res});
        dir_tab.push_back('{mk_in(EV_UPD_WRITE, DS_BAD, 1'b0, PWR_ON, 1'b1, 1'b0, 7'd0),
                           1'b0, none_res});
        dir_tab.push_back('{mk_in(EV_UPD_WRITTEN, DS_OK, 1'b0, PWR_ON, 1'b0, 1'b0, 7'd0),
                           1'b0, none_res});
        dir_tab.push_back('{mk_in(EV_UPD_CLOSED, DS_OK, 1'b0, PWR_ON, 1'b0, 1'b0, 7'd0),
                           1'b0, none_res});

        // Hold reset, then release it on a falling edge
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (n = 0; n < dir_tab.size(); n++)
            send_event(dir_tab[n].item, dir_tab[n].typed, dir_tab[n].res);

        // Random phases, each behind a drained pipe and a new full level
        levels[0] = 7'd0;
        levels[1] = BATT_MAX;
        levels[2] = BATT_W'($urandom_range(1, 99));
        levels[3] = BATT_W'($urandom_range(1, 99));
        levels[4] = BATT_MAX;
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            drain_results();
            set_full_level(levels[ph]);
            // One phase runs flat out on both sides
            idle_pct  = (ph == 2) ? 0 : IDLE_PCT;
            stall_pct = (ph == 2) ? 0 : IDLE_PCT;
            for (n = 0; n < PHASE_ITEMS; n++)
                send_event(random_event(), 1'b0, none_res);
        end

        // Wait out the last results, then keep watching for strays
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/pcef_pkg.sv
rtl/pcef_step.sv
rtl/peripheral_charger_event_fsm_core.sv
sim/peripheral_charger_event_fsm_core_test.sv
